>>> src/format_string_printer_top_assert.svh
`ifndef FORMAT_STRING_PRINTER_TOP_ASSERT_SVH
`define FORMAT_STRING_PRINTER_TOP_ASSERT_SVH

// same-cycle implication, checked on clk_i while out of reset
`define FSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fsp: same-cycle check failed");

// next-cycle implication, checked on clk_i while out of reset
`define FSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fsp: next-cycle check failed");

`endif

>>> src/fsp_pkg.sv
package fsp_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned ArgW      = 64;
  localparam int unsigned WordsW    = 3;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 22;
  localparam int unsigned DigBits   = NumDigits * DigitW;
  localparam int unsigned BcdDigits = 20;
  localparam int unsigned HexDigits = 16;
  localparam int unsigned OctBits   = 3;
  localparam int unsigned RemW      = 5;
  localparam int unsigned StepW     = 6;
  localparam int unsigned InDataW   = CharW + ArgW;
  localparam int unsigned OutDataW  = 16;

  localparam logic [CharW-1:0] ChPercent = 8'h25;
  localparam logic [CharW-1:0] ChMinus   = 8'h2d;
  localparam logic [CharW-1:0] ChH       = 8'h68;
  localparam logic [CharW-1:0] ChL       = 8'h6c;
  localparam logic [CharW-1:0] ChC       = 8'h63;
  localparam logic [CharW-1:0] ChD       = 8'h64;
  localparam logic [CharW-1:0] ChI       = 8'h69;
  localparam logic [CharW-1:0] ChU       = 8'h75;
  localparam logic [CharW-1:0] ChX       = 8'h78;
  localparam logic [CharW-1:0] ChXUp     = 8'h58;
  localparam logic [CharW-1:0] ChP       = 8'h70;
  localparam logic [CharW-1:0] ChO       = 8'h6f;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChAlpha   = 8'h57;

  localparam logic [WordsW-1:0] Words0 = 3'd0;
  localparam logic [WordsW-1:0] Words1 = 3'd1;
  localparam logic [WordsW-1:0] Words2 = 3'd2;
  localparam logic [WordsW-1:0] Words4 = 3'd4;

  typedef enum logic [2:0] {PS_TEXT, PS_PCT, PS_H, PS_L, PS_SPEC} parse_e;
  typedef enum logic [2:0] {LEN_DEF, LEN_HH, LEN_H, LEN_L, LEN_LL} len_e;
  typedef enum logic [1:0] {RDX_DEC, RDX_HEX, RDX_OCT} radix_e;
  typedef enum logic [2:0] {CH_FMT, CH_ARG, CH_PCT, CH_MINUS, CH_DIGIT} char_sel_e;
  typedef enum logic [2:0] {CS_IDLE, CS_CHAR, CS_CONV, CS_SIGN, CS_DIGIT} ctrl_e;

  typedef struct packed {
    logic              load;
    radix_e            radix;
    logic              is_signed;
    len_e              len;
    logic              step;
    logic              advance;
    logic              emit;
    char_sel_e         sel;
    logic              last;
    logic [WordsW-1:0] words;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic neg;
    logic top_zero;
    logic last_digit;
    logic conv_done;
  } sts_t;

  // lowercase ascii digit for radix up to 16
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {{(CharW-DigitW){1'b0}}, d};
    if (d < 4'd10) begin
      return ChZero + dx;
    end else begin
      return ChAlpha + dx;
    end
  endfunction

endpackage

>>> src/fsp_ctrl.sv
module fsp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fsp_pkg::CharW-1:0] fmt_char_i,
  input  fsp_pkg::sts_t             sts_i,
  output fsp_pkg::cmd_t             cmd_o
);
  import fsp_pkg::*;

  ctrl_e             state_q, state_d;
  parse_e            ps_q, ps_d;
  len_e              len_q, len_d;
  char_sel_e         sel_q, sel_d;
  logic [WordsW-1:0] words_q, words_d;
  logic              seen_q, seen_d;
  logic              is_conv;
  logic [WordsW-1:0] num_words;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      ps_q    <= PS_TEXT;
      len_q   <= LEN_DEF;
      sel_q   <= CH_FMT;
      words_q <= Words0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ps_q    <= ps_d;
      len_q   <= len_d;
      sel_q   <= sel_d;
      words_q <= words_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    case (len_q)
      LEN_L:   num_words = Words2;
      LEN_LL:  num_words = Words4;
      default: num_words = Words1;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    ps_d       = ps_q;
    len_d      = len_q;
    sel_d      = sel_q;
    words_d    = words_q;
    seen_d     = seen_q;
    is_conv    = 1'b0;
    cmd_o      = '0;
    cmd_o.len  = len_q;
    in_ready_o = (state_q == CS_IDLE);

    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          seen_d     = 1'b0;
          case (ps_q)
            PS_PCT: begin
              if (fmt_char_i == ChH) begin
                ps_d  = PS_H;
                len_d = LEN_H;
              end else if (fmt_char_i == ChL) begin
                ps_d  = PS_L;
                len_d = LEN_L;
              end else begin
                is_conv = 1'b1;
              end
            end
            PS_H: begin
              if (fmt_char_i == ChH) begin
                ps_d  = PS_SPEC;
                len_d = LEN_HH;
              end else begin
                is_conv = 1'b1;
              end
            end
            PS_L: begin
              if (fmt_char_i == ChL) begin
                ps_d  = PS_SPEC;
                len_d = LEN_LL;
              end else begin
                is_conv = 1'b1;
              end
            end
            PS_SPEC: begin
              is_conv = 1'b1;
            end
            default: begin
              if (fmt_char_i == ChPercent) begin
                ps_d = PS_PCT;
              end else begin
                ps_d    = PS_TEXT;
                sel_d   = CH_FMT;
                words_d = Words0;
                state_d = CS_CHAR;
              end
            end
          endcase

          if (is_conv) begin
            ps_d  = PS_TEXT;
            len_d = LEN_DEF;
            case (fmt_char_i)
              ChC: begin
                sel_d   = CH_ARG;
                words_d = Words1;
                state_d = CS_CHAR;
              end
              ChPercent: begin
                sel_d   = CH_PCT;
                words_d = Words0;
                state_d = CS_CHAR;
              end
              ChD, ChI: begin
                cmd_o.radix     = RDX_DEC;
                cmd_o.is_signed = 1'b1;
                words_d         = num_words;
                state_d         = CS_CONV;
              end
              ChU: begin
                cmd_o.radix = RDX_DEC;
                words_d     = num_words;
                state_d     = CS_CONV;
              end
              ChX, ChXUp, ChP: begin
                cmd_o.radix = RDX_HEX;
                words_d     = num_words;
                state_d     = CS_DIGIT;
              end
              ChO: begin
                cmd_o.radix = RDX_OCT;
                words_d     = num_words;
                state_d     = CS_DIGIT;
              end
              default: begin
                state_d = CS_IDLE;
              end
            endcase
          end
        end
      end

      CS_CHAR: begin
        if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.sel   = sel_q;
          cmd_o.last  = 1'b1;
          cmd_o.words = words_q;
          state_d     = CS_IDLE;
        end
      end

      CS_CONV: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = sts_i.neg ? CS_SIGN : CS_DIGIT;
        end
      end

      CS_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = CH_MINUS;
          state_d    = CS_DIGIT;
        end
      end

      CS_DIGIT: begin
        if (sts_i.top_zero && !seen_q && !sts_i.last_digit) begin
          // leading zero, drop it
          cmd_o.advance = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.advance = 1'b1;
          cmd_o.sel     = CH_DIGIT;
          cmd_o.last    = sts_i.last_digit;
          cmd_o.words   = sts_i.last_digit ? words_q : Words0;
          seen_d        = 1'b1;
          if (sts_i.last_digit) begin
            state_d = CS_IDLE;
          end
        end
      end

      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

>>> src/fsp_datapath.sv
module fsp_datapath #(
  parameter int unsigned IntBits = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fsp_pkg::CharW-1:0]  fmt_char_i,
  input  logic [fsp_pkg::ArgW-1:0]   arg_value_i,
  input  fsp_pkg::cmd_t              cmd_i,
  output fsp_pkg::sts_t              sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [fsp_pkg::CharW-1:0]  out_char_o,
  output logic                       out_last_o,
  output logic [fsp_pkg::WordsW-1:0] out_words_o
);
  import fsp_pkg::*;

  localparam int unsigned LongBits = (2 * IntBits > ArgW) ? ArgW : 2 * IntBits;
  localparam logic [ArgW-1:0] IntMask  = {ArgW{1'b1}} >> (ArgW - IntBits);
  localparam logic [ArgW-1:0] LongMask = {ArgW{1'b1}} >> (ArgW - LongBits);
  localparam logic [ArgW-1:0] FullMask = {ArgW{1'b1}};
  localparam int unsigned BcdW    = BcdDigits * DigitW;
  localparam int unsigned BcdLo   = DigBits - BcdW;
  localparam int unsigned OctSrcW = NumDigits * OctBits;

  logic [ArgW-1:0]    mag_q;
  logic [DigBits-1:0] dig_q;
  logic [CharW-1:0]   fmt_q;
  logic [CharW-1:0]   argb_q;
  logic               neg_q;
  logic [RemW-1:0]    rem_q;
  logic [StepW-1:0]   cnt_q;
  logic               valid_q;
  logic [CharW-1:0]   char_q;
  logic               last_q;
  logic [WordsW-1:0]  words_q;

  logic [ArgW-1:0]    mask;
  logic               sign_bit;
  logic [ArgW-1:0]    val;
  logic               neg_d;
  logic [ArgW-1:0]    mag_d;
  logic [OctSrcW-1:0] oct_src;
  logic [DigBits-1:0] oct_dig;
  logic [DigBits-1:0] hex_dig;
  logic [BcdW-1:0]    adj;
  logic [CharW-1:0]   char_d;

  // operand width and sign from the length modifier
  always_comb begin
    case (cmd_i.len)
      LEN_L: begin
        mask     = LongMask;
        sign_bit = arg_value_i[LongBits-1];
      end
      LEN_LL: begin
        mask     = FullMask;
        sign_bit = arg_value_i[ArgW-1];
      end
      default: begin
        mask     = IntMask;
        sign_bit = arg_value_i[IntBits-1];
      end
    endcase
    val   = arg_value_i & mask;
    neg_d = cmd_i.is_signed & sign_bit;
    // two's complement of the sign-extended value, exact for the most negative one
    mag_d = neg_d ? (~(val | ~mask) + 1'b1) : val;
  end

  always_comb begin
    oct_src = {{(OctSrcW-ArgW){1'b0}}, val};
    for (int i = 0; i < NumDigits; i++) begin
      oct_dig[i*DigitW +: DigitW] = {1'b0, oct_src[i*OctBits +: OctBits]};
    end
    hex_dig = {val, {(DigBits-ArgW){1'b0}}};
  end

  // double-dabble add-3 on every bcd digit
  always_comb begin
    for (int j = 0; j < BcdDigits; j++) begin
      if (dig_q[BcdLo + j*DigitW +: DigitW] >= 4'd5) begin
        adj[j*DigitW +: DigitW] = dig_q[BcdLo + j*DigitW +: DigitW] + 4'd3;
      end else begin
        adj[j*DigitW +: DigitW] = dig_q[BcdLo + j*DigitW +: DigitW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= StepW'(ArgW - 1);
      case (cmd_i.radix)
        RDX_HEX: rem_q <= RemW'(HexDigits);
        RDX_OCT: rem_q <= RemW'(NumDigits);
        default: rem_q <= RemW'(BcdDigits);
      endcase
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - 1'b1;
    end else if (cmd_i.advance) begin
      rem_q <= rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fmt_q  <= fmt_char_i;
      argb_q <= arg_value_i[CharW-1:0];
      neg_q  <= neg_d;
      mag_q  <= mag_d;
      case (cmd_i.radix)
        RDX_HEX: dig_q <= hex_dig;
        RDX_OCT: dig_q <= oct_dig;
        default: dig_q <= '0;
      endcase
    end else if (cmd_i.step) begin
      dig_q[DigBits-1:BcdLo] <= {adj[BcdW-2:0], mag_q[ArgW-1]};
      mag_q                  <= mag_q << 1;
    end else if (cmd_i.advance) begin
      dig_q <= dig_q << DigitW;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      CH_FMT:   char_d = fmt_q;
      CH_ARG:   char_d = argb_q;
      CH_PCT:   char_d = ChPercent;
      CH_MINUS: char_d = ChMinus;
      CH_DIGIT: char_d = digit_char(dig_q[DigBits-1 -: DigitW]);
      default:  char_d = fmt_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q  <= char_d;
      last_q  <= cmd_i.last;
      words_q <= cmd_i.words;
    end
  end

  assign sts_o.out_free   = !valid_q || out_ready_i;
  assign sts_o.neg        = neg_q;
  assign sts_o.top_zero   = (dig_q[DigBits-1 -: DigitW] == '0);
  assign sts_o.last_digit = (rem_q == RemW'(1));
  assign sts_o.conv_done  = (cnt_q == '0);

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_words_o = words_q;

endmodule

>>> src/format_string_printer_top.sv
// printf format interpreter: feed one format byte per beat on the slave side together with
// the current unconsumed argument; the master side returns the printed characters, one per
// beat, with tlast on the final character an input beat caused and the count of argument
// words it consumed (0, 1, 2 or 4) beside that last character. ordinary bytes pass through,
// '%' opens a directive, h/hh/l/ll pick an INT_BITS, 2*INT_BITS or 64-bit argument, and
// c, d, i, u, x, X, p, o or % finish it; unknown conversions and %s print nothing.
// sequencing: a byte that only moves the parser (%, h, l) is taken without leaving idle; a byte
// that prints one character is printed from the char state; hex and octal scan one digit per
// cycle (dropped leading zeros included) while the output register is free; decimal first runs
// a double-dabble pass that shifts in one argument bit per cycle. the single digit-scan register and
// the double-dabble loop set the pace, and each printed character also waits for the
// output register to be taken. one item is worked at a time; the next is accepted once the
// last character of the current one is in the output register.
`include "format_string_printer_top_assert.svh"

module format_string_printer_top #(
  parameter int unsigned INT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fsp_pkg::InDataW-1:0]   s_axis_tdata,   // fmt_char[7:0], arg_value[71:8]
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fsp_pkg::OutDataW-1:0]  m_axis_tdata,   // out_char[7:0], arg_words[10:8], zeros
  output logic                          m_axis_tlast
);
  import fsp_pkg::*;

  localparam int unsigned OutPadW = OutDataW - CharW - WordsW;

  cmd_t              cmd;
  sts_t              sts;
  logic [CharW-1:0]  fmt_char;
  logic [ArgW-1:0]   arg_value;
  logic [CharW-1:0]  out_char;
  logic [WordsW-1:0] arg_words;

  // unpack the input beat
  assign fmt_char  = s_axis_tdata[CharW-1:0];
  assign arg_value = s_axis_tdata[InDataW-1:CharW];

  // parser and sequencing
  fsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .fmt_char_i (fmt_char),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // operand, digit conversion and output register
  fsp_datapath #(
    .IntBits (INT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_char_i  (fmt_char),
    .arg_value_i (arg_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_words_o (arg_words)
  );

  // pack the output beat
  assign m_axis_tdata = {{OutPadW{1'b0}}, arg_words, out_char};

  // a character is only loaded when the output register can take it
  `FSP_ASSERT_IMP(a_emit_when_free, cmd.emit, sts.out_free)
  // no new item while a conversion or digit scan is running
  `FSP_ASSERT_IMP(a_busy_no_accept, cmd.step || cmd.advance, !s_axis_tready)
  // word count only rides on the last character of an item
  `FSP_ASSERT_IMP(a_words_on_last, m_axis_tvalid && !m_axis_tlast,
                  m_axis_tdata[CharW+WordsW-1:CharW] == Words0)
  // the sign always comes ahead of at least one digit
  `FSP_ASSERT_NEXT(a_sign_then_digit, cmd.emit && (cmd.sel == CH_MINUS), !s_axis_tready)

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fsp_pkg::*;

  localparam int unsigned IntBits   = 16;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldLen   = 500;
  localparam int unsigned NumItems  = 280;
  localparam int unsigned DrainLen  = 200;

  // one format byte with the argument word that travels beside it
  typedef struct {
    logic [CharW-1:0] ch;
    logic [ArgW-1:0]  arg;
  } fmt_beat_t;

  // one printed character as it should leave the block
  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              last;
    logic [WordsW-1:0] words;
  } printed_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  fmt_beat_t   fmt_q[$];
  printed_t    printed_q[$];
  parse_e      ps_q  = PS_TEXT;
  len_e        len_q = LEN_DEF;
  int unsigned err_cnt    = 0;
  int unsigned taken_cnt  = 0;
  int unsigned total_cnt  = 0;
  int unsigned out_cnt    = 0;
  int unsigned idle_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  bit          beat_taken = 1'b0;
  bit          calm       = 1'b0;

  format_string_printer_top #(
    .INT_BITS(IntBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic logic [ArgW-1:0] rand_arg();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: return 64'd1 << $urandom_range(0, 63);
      3: return '1;
      4: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic queue_str(input string s, input logic [ArgW-1:0] arg);
    for (int k = 0; k < s.len(); k++) begin
      fmt_q.push_back('{ch: s[k], arg: arg});
    end
  endtask

  // advances the parser by one format byte and queues the characters it prints
  function automatic void print_directive(input logic [CharW-1:0] ch,
                                          input logic [ArgW-1:0] arg);
    printed_t          line[$];
    logic [CharW-1:0]  digs[$];
    logic [WordsW-1:0] words;
    logic              conv;
    logic              numeric;
    logic              sgn;
    logic              neg;
    int unsigned       radix;
    int unsigned       w;
    logic [ArgW-1:0]   mask;
    logic [ArgW-1:0]   v;
    logic [ArgW-1:0]   d;
    words   = Words0;
    conv    = 1'b0;
    numeric = 1'b0;
    sgn     = 1'b0;
    neg     = 1'b0;
    radix   = 10;
    case (ps_q)
      PS_PCT: begin
        if (ch == ChH) begin
          len_q = LEN_H;
          ps_q  = PS_H;
        end else if (ch == ChL) begin
          len_q = LEN_L;
          ps_q  = PS_L;
        end else begin
          conv = 1'b1;
        end
      end
      PS_H: begin
        if (ch == ChH) begin
          len_q = LEN_HH;
          ps_q  = PS_SPEC;
        end else begin
          conv = 1'b1;
        end
      end
      PS_L: begin
        if (ch == ChL) begin
          len_q = LEN_LL;
          ps_q  = PS_SPEC;
        end else begin
          conv = 1'b1;
        end
      end
      PS_SPEC: conv = 1'b1;
      default: begin
        ps_q = PS_TEXT;
        if (ch == ChPercent) begin
          ps_q = PS_PCT;
        end else begin
          line.push_back('{ch: ch, last: 1'b0, words: Words0});
        end
      end
    endcase
    if (conv) begin
      case (ch)
        ChC: begin
          line.push_back('{ch: arg[7:0], last: 1'b0, words: Words0});
          words = Words1;
        end
        ChPercent: line.push_back('{ch: ChPercent, last: 1'b0, words: Words0});
        ChD, ChI: begin
          numeric = 1'b1;
          sgn     = 1'b1;
        end
        ChU: numeric = 1'b1;
        ChX, ChXUp, ChP: begin
          numeric = 1'b1;
          radix   = 16;
        end
        ChO: begin
          numeric = 1'b1;
          radix   = 8;
        end
        default: ;  // string and unknown conversions print nothing
      endcase
      if (numeric) begin
        case (len_q)
          LEN_L: begin
            w     = (2 * IntBits > 64) ? 64 : 2 * IntBits;
            words = Words2;
          end
          LEN_LL: begin
            w     = 64;
            words = Words4;
          end
          default: begin
            w     = IntBits;
            words = Words1;
          end
        endcase
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        v    = arg & mask;
        // sign-extend then negate, so the most negative value keeps its magnitude
        if (sgn && v[w-1]) begin
          neg = 1'b1;
          v   = -(v | ~mask);
        end
        do begin
          d = v % radix;
          digs.push_front((d < 10) ? ChZero + d[7:0] : ChAlpha + d[7:0]);
          v = v / radix;
        end while (v != 0);
        if (neg) begin
          line.push_back('{ch: ChMinus, last: 1'b0, words: Words0});
        end
        foreach (digs[k]) begin
          line.push_back('{ch: digs[k], last: 1'b0, words: Words0});
        end
      end
      ps_q  = PS_TEXT;
      len_q = LEN_DEF;
    end
    if (line.size() != 0) begin
      line[line.size()-1].last  = 1'b1;
      line[line.size()-1].words = words;
    end
    foreach (line[k]) begin
      printed_q.push_back(line[k]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    // keep the log short when the block is badly off
    if (err_cnt <= 100) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // flip between calm stretches and stretches with idling
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt % 256 == 0) begin
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  // output check first, then the input beat is run through the parser
  always @(posedge clk_i) begin
    printed_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_cnt++;
        if (printed_q.size() == 0) begin
          report_mismatch($sformatf("output beat %h with nothing expected", m_axis_tdata));
        end else begin
          want = printed_q.pop_front();
          if (m_axis_tdata[7:0] !== want.ch) begin
            report_mismatch($sformatf("out_char got %h want %h", m_axis_tdata[7:0], want.ch));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", m_axis_tlast, want.last));
          end
          if (m_axis_tdata[10:8] !== want.words) begin
            report_mismatch($sformatf("arg_words got %0d want %0d",
                                      m_axis_tdata[10:8], want.words));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        print_directive(s_axis_tdata[7:0], s_axis_tdata[InDataW-1:CharW]);
        taken_cnt++;
        beat_taken = 1'b1;
      end
    end
  end

  // sender: holds a beat until taken, then an optional gap
  always @(negedge clk_i) begin
    fmt_beat_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (beat_taken || !s_axis_tvalid) begin
      beat_taken = 1'b0;
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (fmt_q.size() > 0) begin
        cur = fmt_q.pop_front();
        s_axis_tdata  <= {cur.arg, cur.ch};
        s_axis_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the input backs up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_done && out_cnt >= 100) begin
        hold_left = HoldLen;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
    end
    if (idle_cnt >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    string       mods;
    string       convs;
    logic [7:0]  b;
    int unsigned r;
    convs = "cdiuxXpo%s";

    // directed: byte extremes, sign extremes at the int and 64-bit widths, conversions c, d, i, u, X, p, o, % and s
    fmt_q.push_back('{ch: 8'h00, arg: rand_arg()});
    fmt_q.push_back('{ch: 8'hff, arg: rand_arg()});
    queue_str("%d", 64'hffff_ffff_ffff_8000);
    queue_str("%hhi", 64'h0000_0000_0000_7fff);
    queue_str("%lld", 64'h8000_0000_0000_0000);
    queue_str("%llo", '1);
    queue_str("%u", 64'h0000_0000_0000_ffff);
    queue_str("%X", 64'h0);
    queue_str("%p", 64'h1234_5678_9abc_def0);
    queue_str("%c", 64'h0000_0000_0000_1f41);
    queue_str("%%", rand_arg());
    queue_str("%s", rand_arg());
    // modifier mix: the h is taken as an unknown conversion
    queue_str("%lh", rand_arg());

    while (fmt_q.size() < NumItems) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        b = 8'($urandom_range(0, 255));
        fmt_q.push_back('{ch: b, arg: rand_arg()});
      end else if (r < 85) begin
        case ($urandom_range(0, 4))
          0: mods = "";
          1: mods = "h";
          2: mods = "hh";
          3: mods = "l";
          default: mods = "ll";
        endcase
        r = $urandom_range(0, 9);
        queue_str({"%", mods, convs.substr(r, r)}, rand_arg());
      end else if (r < 93) begin
        b = 8'($urandom_range(0, 255));
        queue_str("%", rand_arg());
        fmt_q.push_back('{ch: b, arg: rand_arg()});
      end else begin
        case ($urandom_range(0, 4))
          0: queue_str("%hl", rand_arg());
          1: queue_str("%lh", rand_arg());
          2: queue_str("%hhh", rand_arg());
          3: queue_str("%lll", rand_arg());
          default: queue_str("%llh", rand_arg());
        endcase
      end
    end
    total_cnt = fmt_q.size();

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_cnt != total_cnt) @(posedge clk_i);
    while (printed_q.size() != 0) @(posedge clk_i);
    // catch stray characters after the last expected one
    repeat (DrainLen) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
